>>> rtl/pldc_pkg.sv
`default_nettype none
package pldc_pkg;

   localparam int CodeWidth    = 12;
   localparam int VoltWidth    = 16;
   localparam int PointWidth   = VoltWidth + CodeWidth;
   localparam int FactoryPts   = 11;
   localparam int FactoryChans = 2;
   localparam logic [CodeWidth-1:0] CODE_MAX = 12'd4095;

   localparam logic OP_STORE   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INTERP  = 2'd0,
      STATUS_BELOW   = 2'd1,
      STATUS_ABOVE   = 2'd2,
      STATUS_NO_SEG  = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [VoltWidth-1:0] voltage;
      logic [CodeWidth-1:0]        code;
   } point_type;

   localparam logic signed [VoltWidth-1:0] FACTORY_VOLTS [FactoryPts] = '{
      -16'sd20480, -16'sd16384, -16'sd12288, -16'sd8192, -16'sd4096, 16'sd0,
      16'sd4096, 16'sd8192, 16'sd12288, 16'sd16384, 16'sd20480
   };

   localparam logic [CodeWidth-1:0] FACTORY_CODES [FactoryChans][FactoryPts] = '{
      '{12'd55, 12'd460, 12'd862, 12'd1260, 12'd1666, 12'd2067,
        12'd2470, 12'd2873, 12'd3273, 12'd3677, 12'd4081},
      '{12'd71, 12'd473, 12'd876, 12'd1278, 12'd1678, 12'd2079,
        12'd2482, 12'd2881, 12'd3283, 12'd3686, 12'd4089}
   };

   // Factory default point of a channel, zero outside the factory table
   function automatic point_type factory_point(input logic [2:0] ch, input logic [4:0] pt);
      point_type p;
      p.voltage = '0;
      p.code    = '0;
      if (int'(ch) < FactoryChans && int'(pt) < FactoryPts) begin
         p.voltage = FACTORY_VOLTS[pt[3:0]];
         p.code    = FACTORY_CODES[ch[0]][pt[3:0]];
      end
      return p;
   endfunction

endpackage
`default_nettype wire

>>> rtl/pldc_ram.sv
`default_nettype none
module pldc_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 22
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  waddr,
   input  wire [WIDTH-1:0]          wdata,
   input  wire [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

>>> rtl/piecewise_linear_dac_calibration_unit.sv
`default_nettype none
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  operation channel point_index point_voltage
//                                          point_code target_voltage
// rsp      out        rsp_valid/rsp_ready  dac_code status
//
// A store writes the table when it is accepted. A conversion reads the points in
// turn (a read and a check state per point) through the single table read port,
// then runs a bit-serial multiply and a bit-serial divide and posts the result.
// After reset a fill pass over all CHANNELS*POINTS_PER_CHANNEL entries loads the
// factory points; req_ready stays low meanwhile.
// One item is in work at a time; a result waits in the output register and
// a finished conversion holds until that register is free.
module piecewise_linear_dac_calibration_unit
   import pldc_pkg::*;
#(
   parameter int POINTS_PER_CHANNEL = 11,
   parameter int CHANNELS           = 2
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire                  req_operation,
   input  wire                  req_channel,
   input  wire  [3:0]           req_point_index,
   input  wire  signed [15:0]   req_point_voltage,
   input  wire  [11:0]          req_point_code,
   input  wire  signed [15:0]   req_target_voltage,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [11:0]          rsp_dac_code,
   output logic [1:0]           rsp_status
);

   localparam int Depth = CHANNELS * POINTS_PER_CHANNEL;
   localparam int AW    = $clog2(Depth);
   localparam int PW    = $clog2(POINTS_PER_CHANNEL);

   typedef enum logic [2:0] {
      ST_FILL, ST_IDLE, ST_READ, ST_CHECK, ST_MUL, ST_DIV, ST_DONE
   } state_type;

   state_type state_ff;
   logic [AW-1:0]  fill_addr_ff;
   logic [PW-1:0]  fill_pt_ff;
   logic [2:0]     fill_ch_ff;
   logic           ch_ff;
   logic [PW-1:0]  idx_ff;
   logic signed [15:0] v_ff, first_v_ff, prev_v_ff;
   logic [11:0]    prev_y_ff;
   logic [15:0]    den_ff, a_ff, b_ff;
   logic [11:0]    y1_ff, y2_ff;
   logic [27:0]    acc_ff;
   logic [15:0]    rem_ff;
   logic [11:0]    q_ff;
   logic [3:0]     cnt_ff;
   logic [11:0]    code_ff;
   status_type     status_ff;
   logic           rsp_valid_ff;
   logic [11:0]    rsp_code_ff;
   status_type     rsp_status_ff;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   point_type      ram_wdata, rd_point, fill_point;
   logic [PointWidth-1:0] rdata;

   logic           accept, store_ok, ch_valid;
   logic [AW-1:0]  base;
   logic signed [15:0] cur_v;
   logic [16:0]    diff_a, diff_b, den_full, trial;
   logic [27:0]    acc_in;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dac_code = rsp_code_ff;
   assign rsp_status   = rsp_status_ff;

   assign store_ok = (int'(req_channel) < CHANNELS) &&
                     (int'(req_point_index) < POINTS_PER_CHANNEL);
   assign ch_valid = int'(req_channel) < CHANNELS;
   assign base     = ch_ff ? AW'(POINTS_PER_CHANNEL) : '0;

   assign fill_point = factory_point(fill_ch_ff, 5'(fill_pt_ff));

   // Select table write: factory fill or a store item
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = fill_addr_ff;
      ram_wdata = fill_point;
      if (state_ff == ST_FILL) begin
         ram_we = 1'b1;
      end else if (accept && req_operation == OP_STORE && store_ok) begin
         ram_we            = 1'b1;
         ram_waddr         = (req_channel ? AW'(POINTS_PER_CHANNEL) : '0) +
                             AW'(req_point_index);
         ram_wdata.voltage = req_point_voltage;
         ram_wdata.code    = req_point_code;
      end
   end

   assign ram_raddr = base + AW'(idx_ff);

   pldc_ram #(.WIDTH(PointWidth), .DEPTH(Depth)) u_table (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .raddr    (ram_raddr),
      .rdata_ff (rdata)
   );

   assign rd_point = rdata;
   assign cur_v    = rd_point.voltage;
   assign diff_a   = {cur_v[15], cur_v} - {v_ff[15], v_ff};
   assign diff_b   = {v_ff[15], v_ff} - {prev_v_ff[15], prev_v_ff};
   assign den_full = {cur_v[15], cur_v} - {prev_v_ff[15], prev_v_ff};

   // Shift-add step over one code bit of each endpoint
   assign acc_in = {acc_ff[26:0], 1'b0} + (y1_ff[11] ? 28'(a_ff) : 28'd0) +
                   (y2_ff[11] ? 28'(b_ff) : 28'd0);
   // Restoring divide step
   assign trial  = {rem_ff, acc_ff[11]};

   // Hold state, datapath and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_addr_ff <= '0;
         fill_pt_ff   <= '0;
         fill_ch_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_FILL: begin
               fill_addr_ff <= fill_addr_ff + 1'b1;
               if (int'(fill_pt_ff) == POINTS_PER_CHANNEL - 1) begin
                  fill_pt_ff <= '0;
                  fill_ch_ff <= fill_ch_ff + 1'b1;
               end else begin
                  fill_pt_ff <= fill_pt_ff + 1'b1;
               end
               if (int'(fill_addr_ff) == Depth - 1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept && req_operation == OP_CONVERT) begin
                  ch_ff  <= req_channel;
                  v_ff   <= req_target_voltage;
                  idx_ff <= '0;
                  if (ch_valid) begin
                     state_ff <= ST_READ;
                  end else begin
                     code_ff   <= '0;
                     status_ff <= STATUS_NO_SEG;
                     state_ff  <= ST_DONE;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               prev_v_ff <= cur_v;
               prev_y_ff <= rd_point.code;
               idx_ff    <= idx_ff + 1'b1;
               if (idx_ff == '0) begin
                  first_v_ff <= cur_v;
                  state_ff   <= ST_READ;
               end else if (v_ff >= prev_v_ff && v_ff <= cur_v) begin
                  status_ff <= STATUS_INTERP;
                  if (den_full == '0) begin
                     code_ff  <= prev_y_ff;
                     state_ff <= ST_DONE;
                  end else begin
                     den_ff   <= den_full[15:0];
                     a_ff     <= diff_a[15:0];
                     b_ff     <= diff_b[15:0];
                     y1_ff    <= prev_y_ff;
                     y2_ff    <= rd_point.code;
                     acc_ff   <= '0;
                     cnt_ff   <= '0;
                     state_ff <= ST_MUL;
                  end
               end else if (int'(idx_ff) == POINTS_PER_CHANNEL - 1) begin
                  state_ff <= ST_DONE;
                  if (v_ff < first_v_ff) begin
                     code_ff   <= '0;
                     status_ff <= STATUS_BELOW;
                  end else if (v_ff > cur_v) begin
                     code_ff   <= CODE_MAX;
                     status_ff <= STATUS_ABOVE;
                  end else begin
                     code_ff   <= '0;
                     status_ff <= STATUS_NO_SEG;
                  end
               end else begin
                  state_ff <= ST_READ;
               end
            end
            ST_MUL: begin
               acc_ff <= acc_in;
               y1_ff  <= {y1_ff[10:0], 1'b0};
               y2_ff  <= {y2_ff[10:0], 1'b0};
               if (cnt_ff == 4'd11) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
                  rem_ff   <= acc_in[27:12];
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DIV: begin
               acc_ff <= {acc_ff[26:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (trial >= {1'b0, den_ff}) begin
                  rem_ff <= 16'(trial - {1'b0, den_ff});
                  q_ff   <= {q_ff[10:0], 1'b1};
               end else begin
                  rem_ff <= trial[15:0];
                  q_ff   <= {q_ff[10:0], 1'b0};
               end
               if (cnt_ff == 4'd11) begin
                  code_ff  <= {q_ff[10:0], trial >= {1'b0, den_ff}};
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_code_ff   <= code_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Remainder stays below the divisor through the divide
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divide remainder not below divisor");

   // Above-range results carry the full-scale code
   a_above_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_ABOVE) |-> (rsp_code_ff == CODE_MAX))
      else $error("above-range result without full-scale code");

   // A new result is posted only from the done state
   a_post_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result posted outside done state");

   // No item is taken while the table fills
   a_no_accept_in_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> !req_ready)
      else $error("item accepted during fill");

endmodule
`default_nettype wire
